### rtl/tlsh_pkg.sv
// Types and constants shared by the target lock block.
// No dependencies; compile first.
package tlsh_pkg;

  localparam int unsigned IdW     = 8;   // track id width
  localparam int unsigned HistW   = 10;  // history length width
  localparam int unsigned CntW    = 8;   // pending / cooldown counter width
  localparam int unsigned CfgIdxW = 2;   // configuration register index width

  localparam logic [CntW-1:0] CntMax        = {CntW{1'b1}};
  localparam logic [CntW-1:0] ConfirmReset  = CntW'(5);
  localparam logic [CntW-1:0] CooldownReset = CntW'(5);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONFIRM  = CfgIdxW'(0),
    CFG_COOLDOWN = CfgIdxW'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [IdW-1:0]   track_id;
    logic             eligible;
    logic             ready_to_hit;
    logic [HistW-1:0] history_len;
    logic             frame_end;
  } cand_t;

  typedef struct packed {
    logic            target_valid;
    logic [IdW-1:0]  target_id;
    logic            switched;
    logic [CntW-1:0] pending_count;
    logic [CntW-1:0] cooldown_left;
  } res_t;

  // Present lock, fed back to the accumulator
  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] id;
  } lock_t;

  // One candidate leaving the accumulator, with the frame summary merged in
  typedef struct packed {
    logic           valid;
    logic           frame_end;
    logic           best_valid;
    logic [IdW-1:0] best_id;
    logic           lock_seen;
  } step_t;

endpackage

### rtl/tlsh_if.sv
// Handshake interfaces: candidate requests, result requests and register writes.
// Depends on tlsh_pkg.
interface tlsh_cand_if;
  logic                       valid;
  logic                       ready;
  logic [tlsh_pkg::IdW-1:0]   track_id;
  logic                       eligible;
  logic                       ready_to_hit;
  logic [tlsh_pkg::HistW-1:0] history_len;
  logic                       frame_end;

  modport source (output valid, track_id, eligible, ready_to_hit, history_len, frame_end,
                  input ready);
  modport sink   (input valid, track_id, eligible, ready_to_hit, history_len, frame_end,
                  output ready);
endinterface

interface tlsh_res_if;
  logic                      valid;
  logic                      ready;
  logic                      target_valid;
  logic [tlsh_pkg::IdW-1:0]  target_id;
  logic                      switched;
  logic [tlsh_pkg::CntW-1:0] pending_count;
  logic [tlsh_pkg::CntW-1:0] cooldown_left;

  modport source (output valid, target_valid, target_id, switched, pending_count,
                  cooldown_left, input ready);
  modport sink   (input valid, target_valid, target_id, switched, pending_count,
                  cooldown_left, output ready);
endinterface

interface tlsh_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tlsh_pkg::CfgIdxW-1:0] index;
  logic [tlsh_pkg::CntW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/tlsh_frame_acc.sv
// Input register and per-frame accumulator (running best, lock seen).
// Depends on tlsh_pkg and tlsh_if.
module tlsh_frame_acc (
  input  logic               clk_i,
  input  logic               rst_ni,
  tlsh_cand_if.sink          cand_i,
  input  logic               out_free_i,
  input  tlsh_pkg::lock_t    lock_i,
  output tlsh_pkg::step_t    step_o
);

  logic                       s1_valid_q;
  tlsh_pkg::cand_t            s1_q;
  logic                       adv;

  logic                       best_valid_q, best_valid_d;
  logic [tlsh_pkg::IdW-1:0]   best_id_q, best_id_d;
  logic [tlsh_pkg::HistW-1:0] best_len_q, best_len_d;
  logic                       seen_q, seen_d;
  logic                       take;

  // a frame-end item needs a free result slot to move on
  assign adv          = s1_valid_q && (!s1_q.frame_end || out_free_i);
  assign cand_i.ready = !s1_valid_q || adv;

  always_comb begin
    take = s1_q.eligible && s1_q.ready_to_hit &&
           (!best_valid_q || (s1_q.history_len > best_len_q));
    seen_d = seen_q ||
             (s1_q.eligible && lock_i.valid && (s1_q.track_id == lock_i.id));
    best_valid_d = best_valid_q || take;
    best_id_d    = take ? s1_q.track_id    : best_id_q;
    best_len_d   = take ? s1_q.history_len : best_len_q;
  end

  assign step_o.valid      = adv;
  assign step_o.frame_end  = s1_q.frame_end;
  assign step_o.best_valid = best_valid_d;
  assign step_o.best_id    = best_id_d;
  assign step_o.lock_seen  = seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      best_valid_q <= 1'b0;
      best_id_q    <= '0;
      best_len_q   <= '0;
      seen_q       <= 1'b0;
    end else begin
      if (cand_i.ready) begin
        s1_valid_q <= cand_i.valid;
      end
      if (adv) begin
        if (s1_q.frame_end) begin
          best_valid_q <= 1'b0;
          best_id_q    <= '0;
          best_len_q   <= '0;
          seen_q       <= 1'b0;
        end else begin
          best_valid_q <= best_valid_d;
          best_id_q    <= best_id_d;
          best_len_q   <= best_len_d;
          seen_q       <= seen_d;
        end
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (cand_i.ready && cand_i.valid) begin
      s1_q.track_id     <= cand_i.track_id;
      s1_q.eligible     <= cand_i.eligible;
      s1_q.ready_to_hit <= cand_i.ready_to_hit;
      s1_q.history_len  <= cand_i.history_len;
      s1_q.frame_end    <= cand_i.frame_end;
    end
  end

endmodule

### rtl/tlsh_decide.sv
// Frame-end lock decision, hysteresis counters, config registers, result register.
// Depends on tlsh_pkg and tlsh_if.
module tlsh_decide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlsh_pkg::step_t    step_i,
  output logic               out_free_o,
  output tlsh_pkg::lock_t    lock_o,
  tlsh_cfg_if.sink           cfg_i,
  tlsh_res_if.source         res_o
);

  logic [tlsh_pkg::CntW-1:0] confirm_frames_q, cool_len_q;

  logic                      lock_valid_q, lock_valid_d;
  logic [tlsh_pkg::IdW-1:0]  lock_id_q, lock_id_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [tlsh_pkg::IdW-1:0]  pend_id_q, pend_id_d;
  logic [tlsh_pkg::CntW-1:0] pend_frames_q, pend_frames_d;
  logic [tlsh_pkg::CntW-1:0] cool_q, cool_d;
  logic [tlsh_pkg::CntW-1:0] cool_dec, pend_next;

  logic                      out_valid_q;
  tlsh_pkg::res_t            out_q, out_d;
  logic                      decide;

  assign out_free_o = !out_valid_q || res_o.ready;
  assign decide     = step_i.valid && step_i.frame_end;
  assign lock_o.valid = lock_valid_q;
  assign lock_o.id    = lock_id_q;
  assign cfg_i.ready  = 1'b1;

  assign cool_dec = (cool_q != '0) ? cool_q - tlsh_pkg::CntW'(1) : cool_q;

  always_comb begin
    lock_valid_d  = lock_valid_q;
    lock_id_d     = lock_id_q;
    pend_valid_d  = pend_valid_q;
    pend_id_d     = pend_id_q;
    pend_frames_d = pend_frames_q;
    cool_d        = cool_q;
    pend_next     = '0;
    out_d         = '0;

    priority if (!step_i.best_valid) begin
      pend_valid_d  = 1'b0;
      pend_id_d     = '0;
      pend_frames_d = '0;
      cool_d        = cool_dec;
      if (step_i.lock_seen) begin
        out_d.target_valid = 1'b1;
        out_d.target_id    = lock_id_q;
      end else begin
        lock_valid_d = 1'b0;
        lock_id_d    = '0;
      end
    end else if (!step_i.lock_seen) begin
      // fresh acquisition
      lock_valid_d       = 1'b1;
      lock_id_d          = step_i.best_id;
      pend_valid_d       = 1'b0;
      pend_id_d          = '0;
      pend_frames_d      = '0;
      cool_d             = '0;
      out_d.target_valid = 1'b1;
      out_d.target_id    = step_i.best_id;
      out_d.switched     = 1'b1;
    end else if (lock_id_q == step_i.best_id) begin
      pend_valid_d       = 1'b0;
      pend_id_d          = '0;
      pend_frames_d      = '0;
      cool_d             = cool_dec;
      out_d.target_valid = 1'b1;
      out_d.target_id    = lock_id_q;
    end else if (cool_q != '0) begin
      // switch refused during cooldown
      cool_d             = cool_dec;
      pend_valid_d       = 1'b0;
      pend_id_d          = '0;
      pend_frames_d      = '0;
      out_d.target_valid = 1'b1;
      out_d.target_id    = lock_id_q;
    end else begin
      // challenger must win enough consecutive frames
      if (pend_valid_q && (pend_id_q == step_i.best_id)) begin
        pend_next = (pend_frames_q != tlsh_pkg::CntMax) ?
                    pend_frames_q + tlsh_pkg::CntW'(1) : pend_frames_q;
      end else begin
        pend_next = tlsh_pkg::CntW'(1);
      end
      if (pend_next >= confirm_frames_q) begin
        lock_valid_d       = 1'b1;
        lock_id_d          = step_i.best_id;
        pend_valid_d       = 1'b0;
        pend_id_d          = '0;
        pend_frames_d      = '0;
        cool_d             = cool_len_q;
        out_d.switched     = 1'b1;
        out_d.target_id    = step_i.best_id;
      end else begin
        pend_valid_d       = 1'b1;
        pend_id_d          = step_i.best_id;
        pend_frames_d      = pend_next;
        out_d.target_id    = lock_id_q;
      end
      out_d.target_valid = 1'b1;
    end

    out_d.pending_count = pend_frames_d;
    out_d.cooldown_left = cool_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_frames_q  <= tlsh_pkg::ConfirmReset;
      cool_len_q        <= tlsh_pkg::CooldownReset;
      lock_valid_q      <= 1'b0;
      lock_id_q         <= '0;
      pend_valid_q      <= 1'b0;
      pend_id_q         <= '0;
      pend_frames_q     <= '0;
      cool_q            <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          tlsh_pkg::CFG_CONFIRM:  confirm_frames_q  <= cfg_i.data;
          tlsh_pkg::CFG_COOLDOWN: cool_len_q        <= cfg_i.data;
          default: ;
        endcase
      end
      if (decide) begin
        lock_valid_q  <= lock_valid_d;
        lock_id_q     <= lock_id_d;
        pend_valid_q  <= pend_valid_d;
        pend_id_q     <= pend_id_d;
        pend_frames_q <= pend_frames_d;
        cool_q        <= cool_d;
      end
      if (out_free_o) begin
        out_valid_q <= decide;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.target_valid  = out_q.target_valid;
  assign res_o.target_id     = out_q.target_id;
  assign res_o.switched      = out_q.switched;
  assign res_o.pending_count = out_q.pending_count;
  assign res_o.cooldown_left = out_q.cooldown_left;

  // no result without a target carries an id
  a_idle_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.target_valid |-> out_q.target_id == '0)
    else $error("target_id not zero without target");

  // a shown switch matches the held lock
  a_switch_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.switched |->
      out_q.target_valid && lock_valid_q && (out_q.target_id == lock_id_q))
    else $error("switch result disagrees with lock");

  // pending flag and count move together
  a_pend_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q == (pend_frames_q != '0))
    else $error("pending flag and count disagree");

  // cleared lock carries no id
  a_lock_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lock_valid_q |-> lock_id_q == '0)
    else $error("lock id held without lock");

  // lock state only moves on a frame decision
  a_lock_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !decide |=> $stable(lock_id_q) && $stable(cool_q))
    else $error("lock state moved outside a decision");

endmodule

### rtl/target_lock_with_switch_hysteresis.sv
// Top level of the target lock block with switch hysteresis.
// Depends on tlsh_pkg, tlsh_if, tlsh_frame_acc and tlsh_decide.
//
// Use:
//  - cand_i carries one candidate track per request (id, eligible, ready-to-hit,
//    history length, frame_end). The last candidate of a frame has frame_end set.
//  - res_o gives exactly one result request per frame, for the frame_end
//    candidate: target valid/id, switched flag, pending count, cooldown left.
//    Candidates without frame_end give no result.
//  - cfg_i writes confirm_frames (index 0) and the cooldown length (index 1);
//    other indexes are accepted and dropped. Write only while idle.
// Timing:
//  - a candidate is taken into the input register and folded into the running
//    best from there; a frame_end candidate's result is registered once the
//    result register is free, and res_o.valid comes from that register.
//  - one candidate per cycle sustained while res_o takes its results.
// Stall: while a result sits untaken, a following frame_end candidate holds in
//  the input register and blocks cand_i; candidates ahead of it flow through.
// Reset: lock, pending, cooldown and frame accumulators clear; both
//  registers return to 5. Config port is always ready.
module target_lock_with_switch_hysteresis (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlsh_cand_if.sink  cand_i,
  tlsh_cfg_if.sink   cfg_i,
  tlsh_res_if.source res_o
);

  tlsh_pkg::step_t step;
  tlsh_pkg::lock_t lock;
  logic            out_free;

  // candidate register and frame accumulator
  tlsh_frame_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cand_i     (cand_i),
    .out_free_i (out_free),
    .lock_i     (lock),
    .step_o     (step)
  );

  // lock decision, counters and result register
  tlsh_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .out_free_o (out_free),
    .lock_o     (lock),
    .cfg_i      (cfg_i),
    .res_o      (res_o)
  );

endmodule

### bench/tlsh_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the target lock bench: predicts one result per frame_end request.
// Depends on tlsh_pkg.
package tlsh_tb_pkg;
  import tlsh_pkg::*;

  class lock_scoreboard;
    // register copies
    logic [CntW-1:0]  confirm_frames;
    logic [CntW-1:0]  cool_len;
    // decision state
    logic             lock_valid;
    logic [IdW-1:0]   lock_id;
    logic             pend_valid;
    logic [IdW-1:0]   pend_id;
    logic [CntW-1:0]  pend_frames;
    logic [CntW-1:0]  cool_frames;
    // per-frame running best
    logic             best_valid;
    logic [IdW-1:0]   best_id;
    logic [HistW-1:0] best_len;
    logic             lock_seen;

    res_t        expected_q[$];
    int unsigned n_errors;
    int unsigned n_results;
    int unsigned n_switches;
    int unsigned n_cands;
    int unsigned n_writes;

    function new();
      confirm_frames  = ConfirmReset;
      cool_len        = CooldownReset;
      lock_valid      = 1'b0;
      lock_id         = '0;
      cool_frames     = '0;
      clear_pending();
      clear_best();
      n_errors   = 0;
      n_results  = 0;
      n_switches = 0;
      n_cands    = 0;
      n_writes   = 0;
    endfunction

    function void clear_pending();
      pend_valid  = 1'b0;
      pend_id     = '0;
      pend_frames = '0;
    endfunction

    function void clear_best();
      best_valid = 1'b0;
      best_id    = '0;
      best_len   = '0;
      lock_seen  = 1'b0;
    endfunction

    function void count_down();
      if (cool_frames != '0) cool_frames--;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] data);
      n_writes++;
      case (idx)
        CFG_CONFIRM:  confirm_frames  = data;
        CFG_COOLDOWN: cool_len        = data;
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    // Fold one accepted candidate request in; frame_end yields an expectation.
    function void note_cand(cand_t c);
      res_t r;
      n_cands++;
      if (c.eligible) begin
        if (lock_valid && c.track_id == lock_id) lock_seen = 1'b1;
        if (c.ready_to_hit && (!best_valid || c.history_len > best_len)) begin
          best_valid = 1'b1;
          best_id    = c.track_id;
          best_len   = c.history_len;
        end
      end
      if (!c.frame_end) return;

      r = '0;
      if (!best_valid) begin
        clear_pending();
        count_down();
        if (lock_seen) begin
          r.target_valid = 1'b1;
          r.target_id    = lock_id;
        end else begin
          lock_valid = 1'b0;
          lock_id    = '0;
        end
      end else if (!lock_seen) begin
        // fresh acquisition
        lock_valid = 1'b1;
        lock_id    = best_id;
        clear_pending();
        cool_frames    = '0;
        r.target_valid = 1'b1;
        r.target_id    = best_id;
        r.switched     = 1'b1;
      end else if (lock_id == best_id) begin
        clear_pending();
        count_down();
        r.target_valid = 1'b1;
        r.target_id    = lock_id;
      end else if (cool_frames != '0) begin
        cool_frames--;
        clear_pending();
        r.target_valid = 1'b1;
        r.target_id    = lock_id;
      end else begin
        if (pend_valid && pend_id == best_id) begin
          if (pend_frames != CntMax) pend_frames++;
        end else begin
          pend_valid  = 1'b1;
          pend_id     = best_id;
          pend_frames = CntW'(1);
        end
        if (pend_frames >= confirm_frames) begin
          lock_valid = 1'b1;
          lock_id    = best_id;
          clear_pending();
          cool_frames = cool_len;
          r.switched  = 1'b1;
        end
        r.target_valid = 1'b1;
        r.target_id    = lock_id;
      end
      r.pending_count = pend_frames;
      r.cooldown_left = cool_frames;
      clear_best();
      if (r.switched) n_switches++;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        n_errors++;
        if (n_errors <= 40)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 40)
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      cmp_field("target_valid",  want.target_valid,  got.target_valid);
      cmp_field("target_id",     want.target_id,     got.target_id);
      cmp_field("switched",      want.switched,      got.switched);
      cmp_field("pending_count", want.pending_count, got.pending_count);
      cmp_field("cooldown_left", want.cooldown_left, got.cooldown_left);
    endfunction
  endclass

endpackage

### bench/tb.sv
`timescale 1ns / 100ps
// Top of the target lock bench: drives candidate and register requests, takes results.
// Depends on tlsh_pkg, tlsh_if, tlsh_tb_pkg and the block's RTL.
module tb;
  import tlsh_pkg::*;
  import tlsh_tb_pkg::*;

  localparam int unsigned PhaseItems  = 205;   // candidates per random phase
  localparam int unsigned HoldCycles  = 400;   // long receiver hold-off
  localparam int unsigned StallLimit  = 3000;  // cycles with no request moving
  localparam int unsigned DrainCycles = 6;     // settle time after the last outstanding result
  localparam logic [CfgIdxW-1:0] CfgUnmapped = CfgIdxW'(3);

  logic clk_i;
  logic rst_ni;

  tlsh_cand_if cand_bus ();
  tlsh_cfg_if  cfg_bus ();
  tlsh_res_if  res_bus ();

  target_lock_with_switch_hysteresis i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand_i (cand_bus),
    .cfg_i  (cfg_bus),
    .res_o  (res_bus)
  );

  lock_scoreboard  tracker;
  bit              hold_req = 1'b0;     // sender asks the receiver for a long hold
  int unsigned     stall_cycles = 0;
  logic [IdW-1:0]  id_pool [6];         // small id set so challengers repeat
  logic [IdW-1:0]  rival_id;            // current favoured challenger

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Request drivers. All drive with NBAs at the rising edge; an accept is seen
  // at the first edge with valid and ready both high (pre-edge values).
  // ---------------------------------------------------------------------------
  function automatic cand_t track_req(logic [IdW-1:0] id, logic elig, logic rdy,
                                      logic [HistW-1:0] len, logic fend);
    cand_t c;
    c.track_id     = id;
    c.eligible     = elig;
    c.ready_to_hit = rdy;
    c.history_len  = len;
    c.frame_end    = fend;
    return c;
  endfunction

  task automatic offer_cand(cand_t c);
    cand_bus.valid        <= 1'b1;
    cand_bus.track_id     <= c.track_id;
    cand_bus.eligible     <= c.eligible;
    cand_bus.ready_to_hit <= c.ready_to_hit;
    cand_bus.history_len  <= c.history_len;
    cand_bus.frame_end    <= c.frame_end;
    do @(posedge clk_i); while (!cand_bus.ready);
    tracker.note_cand(c);
  endtask

  // Drops valid for an idle gap set by n; n == 0 keeps valid high for back-to-back requests.
  task automatic idle_cand(int unsigned n);
    if (n == 0) return;
    cand_bus.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    tracker.write_reg(idx, data);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every outstanding frame result, then let the pipe settle.
  task automatic drain();
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One frame of candidates. Most frames carry the present lock and the
  // favoured challenger with a long history, so confirm counts build up;
  // noisy frames are fully random.
  task automatic send_frame(bit noisy, bit burst);
    int unsigned      n;
    int unsigned      lock_at;
    int unsigned      rival_at;
    logic [HistW-1:0] rival_len;
    cand_t            c;
    n         = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
    lock_at   = ($urandom_range(0, 7) != 0 && tracker.lock_valid) ? $urandom_range(0, n-1) : n;
    rival_at  = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n-1) : n;
    rival_len = HistW'($urandom_range(600, 1023));
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy) begin
        c = track_req(IdW'($urandom()), 1'($urandom()), 1'($urandom()),
                      HistW'($urandom()), 1'b0);
      end else if (i == rival_at) begin
        c = track_req(rival_id, 1'b1, 1'b1, rival_len, 1'b0);
      end else if (i == lock_at) begin
        c = track_req(tracker.lock_id, 1'b1, 1'($urandom()), HistW'($urandom()), 1'b0);
      end else begin
        c.track_id     = ($urandom_range(0, 3) == 0) ? IdW'($urandom())
                                                     : id_pool[$urandom_range(0, 5)];
        c.eligible     = ($urandom_range(0, 7) != 0);
        c.ready_to_hit = ($urandom_range(0, 3) != 0);
        // occasional tie with the challenger: first arrival wins
        c.history_len  = ($urandom_range(0, 5) == 0) ? rival_len
                                                     : HistW'($urandom_range(0, 700));
      end
      c.frame_end = (i == n - 1);
      offer_cand(c);
      if (!burst) idle_cand(pick_gap());
    end
  endtask

  task automatic run_phase(logic [CntW-1:0] confirm, logic [CntW-1:0] cooldown,
                           bit long_hold, bit extreme_ids);
    int unsigned start;
    write_reg(CFG_CONFIRM, confirm);
    write_reg(CFG_COOLDOWN, cooldown);
    foreach (id_pool[i]) id_pool[i] = IdW'($urandom());
    if (extreme_ids) begin
      id_pool[0] = '0;
      id_pool[1] = '1;
    end
    rival_id = id_pool[0];
    start    = tracker.n_cands;
    // receiver stops taking results while we keep offering: input must back up
    if (long_hold) hold_req = 1'b1;
    while (tracker.n_cands - start < PhaseItems) begin
      if ($urandom_range(0, 5) == 0) rival_id = id_pool[$urandom_range(0, 5)];
      send_frame($urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0);
    end
    cand_bus.valid <= 1'b0;
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready pattern, long hold on request from the sender.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        for (int unsigned k = 0; k < HoldCycles; k++) @(posedge clk_i);
      end else if (mode < 55) begin
        res_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (mode < 85) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else if (mode < 95) begin
        // long stretch with no back-pressure
        res_bus.ready <= 1'b1;
        repeat ($urandom_range(60, 150)) @(posedge clk_i);
      end else begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready)
      tracker.check_result({res_bus.target_valid, res_bus.target_id, res_bus.switched,
                            res_bus.pending_count, res_bus.cooldown_left});
  end

  // Watchdog: counts cycles in which no request of any kind moves.
  always @(posedge clk_i) begin
    if ((cand_bus.valid && cand_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: no request moved for %0d cycles", $time, StallLimit);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tracker               = new();
    rst_ni                = 1'b0;
    cand_bus.valid        = 1'b0;
    cand_bus.track_id     = '0;
    cand_bus.eligible     = 1'b0;
    cand_bus.ready_to_hit = 1'b0;
    cand_bus.history_len  = '0;
    cand_bus.frame_end    = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_CONFIRM;
    cfg_bus.data          = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values (confirm 5, cooldown 5).
    // fresh acquisition of id 0 with empty history
    offer_cand(track_req('0, 1'b1, 1'b1, '0, 1'b1));
    // dummy with max fields ignored; lock seen but not ready: no best, lock kept
    offer_cand(track_req('1, 1'b0, 1'b1, '1, 1'b0));
    offer_cand(track_req('0, 1'b1, 1'b0, HistW'(5), 1'b1));
    // tie at max length: earlier id 7 wins, starts pending against lock 0
    offer_cand(track_req(IdW'(7), 1'b1, 1'b1, '1, 1'b0));
    idle_cand(pick_gap());
    offer_cand(track_req(IdW'(9), 1'b1, 1'b1, '1, 1'b0));
    offer_cand(track_req('0, 1'b1, 1'b1, '1, 1'b1));
    // lock absent, new best: immediate takeover by id 255
    offer_cand(track_req('1, 1'b1, 1'b1, '1, 1'b1));
    // no best and lock absent: lock drops, no target
    offer_cand(track_req(IdW'(3), 1'b0, 1'b0, '0, 1'b1));
    cand_bus.valid <= 1'b0;
    drain();

    // Directed, confirm zero: a challenger switches at once unless cooldown refuses it
    write_reg(CFG_CONFIRM, '0);
    write_reg(CFG_COOLDOWN, CntW'(2));
    offer_cand(track_req(IdW'(10), 1'b1, 1'b1, HistW'(4), 1'b1));
    offer_cand(track_req(IdW'(10), 1'b1, 1'b1, HistW'(3), 1'b0));
    offer_cand(track_req(IdW'(20), 1'b1, 1'b1, HistW'(4), 1'b1));
    // cooldown refuses the next challenger
    offer_cand(track_req(IdW'(20), 1'b1, 1'b1, HistW'(1), 1'b0));
    offer_cand(track_req(IdW'(30), 1'b1, 1'b1, HistW'(9), 1'b1));
    // lock seen, nobody ready: kept, cooldown runs out
    offer_cand(track_req(IdW'(20), 1'b1, 1'b0, '0, 1'b1));
    cand_bus.valid <= 1'b0;
    drain();

    // Random phases across register settings, extremes included
    run_phase(CntW'(1), '0, 1'b0, 1'b0);
    run_phase(CntW'(3), CntW'(2), 1'b1, 1'b0);
    run_phase('0, '1, 1'b0, 1'b1);
    run_phase('1, '0, 1'b0, 1'b0);
    write_reg(CfgUnmapped, '1);  // dropped by the block
    run_phase(CntW'(2), CntW'(1), 1'b0, 1'b1);
    run_phase(CntW'($urandom_range(1, 4)), CntW'($urandom_range(0, 3)), 1'b0, 1'b0);
    run_phase(CntW'($urandom_range(1, 4)), CntW'($urandom_range(0, 3)), 1'b0, 1'b0);
    run_phase(CntW'(4), CntW'(3), 1'b0, 1'b0);

    if (tracker.expected_q.size() != 0) begin
      tracker.n_errors++;
      $display("%0t: %0d frame results never arrived: expected 0 outstanding, actual %0d",
               $time, tracker.expected_q.size(), tracker.expected_q.size());
    end
    $display("Covered %0d candidates, %0d frame results and %0d lock switches",
             tracker.n_cands, tracker.n_results, tracker.n_switches);
    $display("over %0d register writes; %0d mismatches", tracker.n_writes, tracker.n_errors);
    if (tracker.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/tlsh_pkg.sv
rtl/tlsh_if.sv
rtl/tlsh_frame_acc.sv
rtl/tlsh_decide.sv
rtl/target_lock_with_switch_hysteresis.sv
bench/tlsh_tb_pkg.sv
bench/tb.sv
